@@ sv/sha1md_pkg.sv @@
// ----------------------------------------------------------------------------
// sha1md_pkg
// Shared types and constants of the SHA-1 message digest core.
// ----------------------------------------------------------------------------
package sha1md_pkg;

    localparam int WORD_W      = 32;
    localparam int BYTE_W      = 8;
    localparam int BLOCK_BITS  = 512;
    localparam int ROUND_W     = 7;
    localparam int FILL_W      = 6;
    localparam int COUNT_W     = 64;
    localparam int LEN_IDX_W   = 4;
    localparam int WORD_IDX_W  = 3;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [BYTE_W-1:0] t_byte;

    typedef struct packed {
        t_word a;
        t_word b;
        t_word c;
        t_word d;
        t_word e;
    } t_vars;

    // Control from the sequencer to the block buffer.
    typedef struct packed {
        logic  push;
        t_byte data;
        logic  step;
    } t_buf_ctl;

    localparam t_vars INIT_CHAIN = '{
        a: 32'h67452301,
        b: 32'hEFCDAB89,
        c: 32'h98BADCFE,
        d: 32'h10325476,
        e: 32'hC3D2E1F0
    };

    localparam t_word K_0 = 32'h5A827999;
    localparam t_word K_1 = 32'h6ED9EBA1;
    localparam t_word K_2 = 32'h8F1BBCDC;
    localparam t_word K_3 = 32'hCA62C1D6;

    localparam logic [ROUND_W-1:0] ROUND_Q1   = 7'd20;
    localparam logic [ROUND_W-1:0] ROUND_Q2   = 7'd40;
    localparam logic [ROUND_W-1:0] ROUND_Q3   = 7'd60;
    localparam logic [ROUND_W-1:0] ROUND_LAST = 7'd79;

    localparam t_byte                   PAD_BYTE      = 8'h80;
    localparam logic [FILL_W-1:0]       FILL_LAST     = 6'd63;
    localparam logic [FILL_W-1:0]       LEN_POS       = 6'd56;
    localparam logic [FILL_W-1:0]       LEN_TOP_SHIFT = 6'd56;
    localparam logic [LEN_IDX_W-1:0]    LEN_BYTES     = 4'd8;
    localparam logic [WORD_IDX_W-1:0]   WORD_LAST     = 3'd4;
    localparam logic [COUNT_W-1:0]      BITS_PER_BYTE = 64'd8;

endpackage

@@ sv/sha1md_if.sv @@
// ----------------------------------------------------------------------------
// sha1md_in_if / sha1md_out_if
// Valid/ready channels for message bytes and digest words.
// ----------------------------------------------------------------------------
interface sha1md_in_if;
    logic       valid;
    logic       ready;
    logic       has_byte;
    logic [7:0] message_byte;
    logic       end_of_message;

    modport source(output valid, has_byte, message_byte, end_of_message, input ready);
    modport sink(input valid, has_byte, message_byte, end_of_message, output ready);
endinterface

interface sha1md_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source(output valid, digest_word, word_index, last_word, input ready);
    modport sink(input valid, digest_word, word_index, last_word, output ready);
endinterface

@@ sv/sha1md_round.sv @@
// ----------------------------------------------------------------------------
// sha1md_round
// One SHA-1 compression round, shared by all 80 rounds of a block.
// ----------------------------------------------------------------------------
module sha1md_round
    import sha1md_pkg::*;
(
    input  t_vars              i_vars,
    input  t_word              i_w,
    input  logic [ROUND_W-1:0] i_round,
    output t_vars              o_vars
);

    t_word f;
    t_word k;
    t_word tmp;

    always_comb begin
        if (i_round < ROUND_Q1) begin
            f = (i_vars.b & i_vars.c) | (~i_vars.b & i_vars.d);
            k = K_0;
        end else if (i_round < ROUND_Q2) begin
            f = i_vars.b ^ i_vars.c ^ i_vars.d;
            k = K_1;
        end else if (i_round < ROUND_Q3) begin
            f = (i_vars.b & i_vars.c) | (i_vars.b & i_vars.d) | (i_vars.c & i_vars.d);
            k = K_2;
        end else begin
            f = i_vars.b ^ i_vars.c ^ i_vars.d;
            k = K_3;
        end
    end

    assign tmp = {i_vars.a[26:0], i_vars.a[31:27]} + f + i_vars.e + k + i_w;

    assign o_vars = '{
        a: tmp,
        b: i_vars.a,
        c: {i_vars.b[1:0], i_vars.b[31:2]},
        d: i_vars.c,
        e: i_vars.d
    };

endmodule

@@ sv/sha1md_buffer.sv @@
// ----------------------------------------------------------------------------
// sha1md_buffer
// Block buffer that collects bytes and then serves as the schedule window.
// ----------------------------------------------------------------------------
module sha1md_buffer
    import sha1md_pkg::*;
(
    input  logic     i_clk,
    input  t_buf_ctl i_ctl,
    output t_word    o_w
);

    logic [BLOCK_BITS-1:0] r_buf;
    t_word                 w0;
    t_word                 w2;
    t_word                 w8;
    t_word                 w13;
    t_word                 mix;

    // Word j of the window sits at the top when j is zero; bytes enter at the bottom.
    assign w0  = r_buf[BLOCK_BITS-1            -: WORD_W];
    assign w2  = r_buf[BLOCK_BITS-1-2*WORD_W   -: WORD_W];
    assign w8  = r_buf[BLOCK_BITS-1-8*WORD_W   -: WORD_W];
    assign w13 = r_buf[BLOCK_BITS-1-13*WORD_W  -: WORD_W];
    assign mix = w13 ^ w8 ^ w2 ^ w0;
    assign o_w = w0;

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_buf <= {r_buf[BLOCK_BITS-BYTE_W-1:0], i_ctl.data};
        end else if (i_ctl.step) begin
            r_buf <= {r_buf[BLOCK_BITS-WORD_W-1:0], mix[30:0], mix[31]};
        end
    end

endmodule

@@ sv/sha1_message_digest_core.sv @@
// ----------------------------------------------------------------------------
// sha1_message_digest_core
// SHA-1 over a byte stream with padding and five-word digest output.
// ----------------------------------------------------------------------------
// A byte that does not fill the block is simply stored in the block buffer. The byte
// that fills a block starts a compression: its transfer also loads the working
// variables, then come 80 rounds of the shared round unit and one chaining add, and no
// new byte is taken until that is done. Finalizing pushes one pad byte a cycle (up to
// 72), compresses one or two blocks and then offers five digest transfers, one a cycle
// while the sink is ready. Reset is synchronous, active low, and restores the initial
// hash values with empty length and fill.
module sha1_message_digest_core
    import sha1md_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    sha1md_in_if.sink     i_msg,
    sha1md_out_if.source  o_dig
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_ROUND,
        S_ADD,
        S_OUT
    } t_state;

    t_state                 r_state,    n_state;
    logic [FILL_W-1:0]      r_fill,     n_fill;
    logic [COUNT_W-1:0]     r_bits,     n_bits;
    t_vars                  r_chain,    n_chain;
    t_vars                  r_vars,     n_vars;
    logic [ROUND_W-1:0]     r_round,    n_round;
    logic                   r_final,    n_final;
    logic                   r_marked,   n_marked;
    logic [LEN_IDX_W-1:0]   r_len_idx,  n_len_idx;
    logic [WORD_IDX_W-1:0]  r_word_idx, n_word_idx;
    logic                   r_out_valid, n_out_valid;

    t_buf_ctl               buf_ctl;
    t_word                  sched_w;
    t_vars                  round_out;
    logic                   full;
    logic [FILL_W-1:0]      len_shift;
    logic [COUNT_W-1:0]     len_word;

    sha1md_buffer u_buffer (
        .i_clk (i_clk),
        .i_ctl (buf_ctl),
        .o_w   (sched_w)
    );

    sha1md_round u_round (
        .i_vars  (r_vars),
        .i_w     (sched_w),
        .i_round (r_round),
        .o_vars  (round_out)
    );

    assign full      = (r_fill == FILL_LAST);
    assign len_shift = LEN_TOP_SHIFT - {r_len_idx[2:0], 3'b000};
    assign len_word  = r_bits >> len_shift;

    assign i_msg.ready       = (r_state == S_IDLE);
    assign o_dig.valid       = r_out_valid;
    assign o_dig.word_index  = r_word_idx;
    assign o_dig.last_word   = (r_word_idx == WORD_LAST);

    always_comb begin
        case (r_word_idx)
            3'd0:    o_dig.digest_word = r_chain.a;
            3'd1:    o_dig.digest_word = r_chain.b;
            3'd2:    o_dig.digest_word = r_chain.c;
            3'd3:    o_dig.digest_word = r_chain.d;
            default: o_dig.digest_word = r_chain.e;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_bits      = r_bits;
        n_chain     = r_chain;
        n_vars      = r_vars;
        n_round     = r_round;
        n_final     = r_final;
        n_marked    = r_marked;
        n_len_idx   = r_len_idx;
        n_word_idx  = r_word_idx;
        n_out_valid = r_out_valid;
        buf_ctl     = '{push: 1'b0, data: '0, step: 1'b0};

        case (r_state)
            S_IDLE: begin
                if (i_msg.valid) begin
                    if (i_msg.has_byte) begin
                        buf_ctl.push = 1'b1;
                        buf_ctl.data = i_msg.message_byte;
                        n_fill       = r_fill + 1'b1;
                        n_bits       = r_bits + BITS_PER_BYTE;
                    end
                    if (i_msg.has_byte && full) begin
                        n_state = S_ROUND;
                        n_round = '0;
                        n_vars  = r_chain;
                        n_final = i_msg.end_of_message;
                    end else if (i_msg.end_of_message) begin
                        n_state = S_PAD;
                        n_final = 1'b1;
                    end
                end
            end
            S_PAD: begin
                // The marker byte comes first, then zeros up to the length field, then the length bytes.
                buf_ctl.push = 1'b1;
                n_fill       = r_fill + 1'b1;
                if (!r_marked) begin
                    buf_ctl.data = PAD_BYTE;
                    n_marked     = 1'b1;
                end else if ((r_len_idx != '0) || (r_fill == LEN_POS)) begin
                    buf_ctl.data = len_word[BYTE_W-1:0];
                    n_len_idx    = r_len_idx + 1'b1;
                end else begin
                    buf_ctl.data = '0;
                end
                if (full) begin
                    n_state = S_ROUND;
                    n_round = '0;
                    n_vars  = r_chain;
                end
            end
            S_ROUND: begin
                buf_ctl.step = 1'b1;
                n_vars       = round_out;
                n_round      = r_round + 1'b1;
                if (r_round == ROUND_LAST) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                n_chain.a = r_chain.a + r_vars.a;
                n_chain.b = r_chain.b + r_vars.b;
                n_chain.c = r_chain.c + r_vars.c;
                n_chain.d = r_chain.d + r_vars.d;
                n_chain.e = r_chain.e + r_vars.e;
                if (r_len_idx == LEN_BYTES) begin
                    n_state     = S_OUT;
                    n_out_valid = 1'b1;
                    n_word_idx  = '0;
                end else if (r_final) begin
                    n_state = S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                if (o_dig.ready) begin
                    if (r_word_idx == WORD_LAST) begin
                        n_state     = S_IDLE;
                        n_out_valid = 1'b0;
                        n_chain     = INIT_CHAIN;
                        n_fill      = '0;
                        n_bits      = '0;
                        n_final     = 1'b0;
                        n_marked    = 1'b0;
                        n_len_idx   = '0;
                        n_word_idx  = '0;
                    end else begin
                        n_word_idx = r_word_idx + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_bits      <= '0;
            r_chain     <= INIT_CHAIN;
            r_round     <= '0;
            r_final     <= 1'b0;
            r_marked    <= 1'b0;
            r_len_idx   <= '0;
            r_word_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_bits      <= n_bits;
            r_chain     <= n_chain;
            r_round     <= n_round;
            r_final     <= n_final;
            r_marked    <= n_marked;
            r_len_idx   <= n_len_idx;
            r_word_idx  <= n_word_idx;
            r_out_valid <= n_out_valid;
        end
        r_vars <= n_vars;
    end

    // Input and output sides are never open at the same time.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_msg.ready && o_dig.valid))
        else $error("input ready while a digest word is offered");

    // The round counter never runs past the last round.
    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND) |-> (r_round <= ROUND_LAST))
        else $error("round counter out of range");

    // The length field never grows past eight bytes.
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len_idx <= LEN_BYTES)
        else $error("length byte count out of range");

    // The length field ends exactly at a block boundary.
    a_len_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PAD && r_len_idx == 4'd7) |-> full)
        else $error("length field does not end the block");

    // After the last digest transfer the block is back at its initial state.
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_dig.valid && o_dig.ready && o_dig.last_word) |=>
        (r_state == S_IDLE && r_fill == '0 && r_bits == '0 && r_chain == INIT_CHAIN))
        else $error("no restart after the final digest word");

endmodule
